// ===== src/pad_crop_flip_image_store_top_assert.svh =====
// assertion macros for the pad/crop/flip image store
// used by pad_crop_flip_image_store_top; expects clk and rst_n in scope
`ifndef PAD_CROP_FLIP_IMAGE_STORE_TOP_ASSERT_SVH
`define PAD_CROP_FLIP_IMAGE_STORE_TOP_ASSERT_SVH

// checked only while out of reset
`define PCFIS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define PCFIS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/pcfis_pkg.sv =====
// shared types and constants for the pad/crop/flip image store
// no dependencies; imported by every module of the block
package pcfis_pkg;

    localparam int PIX_W   = 32;
    localparam int IDX_W   = 5;
    localparam int SIDE_W  = 6;
    localparam int CROP_W  = 7;
    localparam int COORD_W = 6;

    localparam int CMD_Q_DEPTH = 2;
    localparam int RSP_Q_DEPTH = 2;

    // action codes
    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_FETCH = 1'b1;

    // configuration register indexes (byte address / 4)
    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 32;
    localparam logic [2:0] REG_SIDE   = 3'd0;
    localparam logic [2:0] REG_PAD    = 3'd1;
    localparam logic [2:0] REG_CROP_Y = 3'd2;
    localparam logic [2:0] REG_CROP_X = 3'd3;
    localparam logic [2:0] REG_MIRROR = 3'd4;

    localparam logic [SIDE_W-1:0] SIDE_RESET   = 6'd32;
    localparam logic [SIDE_W-1:0] PAD_RESET    = 6'd4;
    localparam logic [CROP_W-1:0] CROP_RESET   = 7'd0;
    localparam logic              MIRROR_RESET = 1'b0;

    typedef struct packed {
        logic             action;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic [PIX_W-1:0] pixel_in;
    } req_t;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_out;
        logic             is_padding;
        logic             range_error;
    } rsp_t;

    typedef struct packed {
        logic [SIDE_W-1:0] side;
        logic [SIDE_W-1:0] pad;
        logic [CROP_W-1:0] crop_y;
        logic [CROP_W-1:0] crop_x;
        logic              mirror;
    } cfg_t;

    // classified work item between front and back
    typedef struct packed {
        logic               is_load;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] x;
        logic [PIX_W-1:0]   word;
        logic               is_padding;
        logic               range_error;
    } cmd_t;

endpackage

// ===== src/pad_crop_flip_image_store_top.sv =====
// top level of the pad/crop/flip image store: config registers and wiring
// depends on pcfis_pkg, pcfis_front, pcfis_queue, pcfis_back and the assert header
//
//  channel  direction  handshake              payload
//  req      in         req_valid / req_ready  req_t (action, row, col, pixel_in)
//  rsp      out        rsp_valid / rsp_ready  rsp_t (pixel_out, is_padding, range_error)
//  apb      in         psel/penable/pready    paddr, pwdata, prdata
//
// one item per cycle sustained while results are taken; the single store port takes one load or one read each cycle
// a fetch result passes the command queue, the registered store read and the result queue
// loads produce no result; a load passes the command queue before it is written to the store
// either side may stall on its own: the command queue and the result queue absorb it
// reset clears control state only; the store holds whatever it held until loaded
`include "pad_crop_flip_image_store_top_assert.svh"

module pad_crop_flip_image_store_top
    import pcfis_pkg::*;
#(
    parameter int MAX_SIDE = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    input  logic                  req_valid,
    output logic                  req_ready,
    input  req_t                  req,
    output logic                  rsp_valid,
    input  logic                  rsp_ready,
    output rsp_t                  rsp
);

    cfg_t       cfg_reg;
    logic       cfg_we;
    logic [2:0] reg_idx;

    logic q_ready;
    logic q_push;
    cmd_t q_cmd;
    logic cmd_valid;
    logic cmd_ready;
    cmd_t cmd;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign cfg_we  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.side   <= SIDE_RESET;
            cfg_reg.pad    <= PAD_RESET;
            cfg_reg.crop_y <= CROP_RESET;
            cfg_reg.crop_x <= CROP_RESET;
            cfg_reg.mirror <= MIRROR_RESET;
        end
        else if (cfg_we)
        begin
            unique case (reg_idx)
                REG_SIDE:   cfg_reg.side   <= pwdata[SIDE_W-1:0];
                REG_PAD:    cfg_reg.pad    <= pwdata[SIDE_W-1:0];
                REG_CROP_Y: cfg_reg.crop_y <= pwdata[CROP_W-1:0];
                REG_CROP_X: cfg_reg.crop_x <= pwdata[CROP_W-1:0];
                REG_MIRROR: cfg_reg.mirror <= pwdata[0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_SIDE:   prdata = CFG_DATA_W'(cfg_reg.side);
            REG_PAD:    prdata = CFG_DATA_W'(cfg_reg.pad);
            REG_CROP_Y: prdata = CFG_DATA_W'(cfg_reg.crop_y);
            REG_CROP_X: prdata = CFG_DATA_W'(cfg_reg.crop_x);
            REG_MIRROR: prdata = CFG_DATA_W'(cfg_reg.mirror);
            default:    prdata = '0;
        endcase
    end

    pcfis_front #(
        .MAX_SIDE (MAX_SIDE)
    ) u_front (
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .cfg       (cfg_reg),
        .q_ready   (q_ready),
        .q_push    (q_push),
        .q_cmd     (q_cmd)
    );

    pcfis_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_cmd   (q_cmd),
        .push_ready (q_ready),
        .pop_valid  (cmd_valid),
        .pop_ready  (cmd_ready),
        .pop_cmd    (cmd)
    );

    pcfis_back #(
        .MAX_SIDE (MAX_SIDE)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    // a fetch is padding, out of range or neither, never both
    `PCFIS_ASSERT(a_cmd_flags_excl, cmd_valid |-> !(cmd.is_padding && cmd.range_error), "padding and range flags both set")
    // out-of-range fetch returns a zero word without the padding flag
    `PCFIS_ASSERT(a_range_zero, (rsp_valid && rsp.range_error) |-> (rsp.pixel_out == '0 && !rsp.is_padding), "range error result not clean")
    // padding positions read as zero
    `PCFIS_ASSERT(a_pad_zero, (rsp_valid && rsp.is_padding) |-> (rsp.pixel_out == '0), "padding result not zero")
    // the output is never valid in the cycle after one with reset low
    `PCFIS_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !rsp_valid, "result valid right after reset")

endmodule

// ===== src/pcfis_front.sv =====
// front end: accepts items, maps fetch coordinates through pad/crop/mirror
// depends on pcfis_pkg; feeds pcfis_queue
module pcfis_front
    import pcfis_pkg::*;
#(
    parameter int MAX_SIDE = 32
)
(
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    input  cfg_t cfg,
    input  logic q_ready,
    output logic q_push,
    output cmd_t q_cmd
);

    localparam int SIDE_CAP = (MAX_SIDE > 63) ? 63 : MAX_SIDE;

    logic [SIDE_W-1:0]  eff_side;
    logic [CROP_W-1:0]  crop_lim;
    logic [CROP_W-1:0]  cy;
    logic [CROP_W-1:0]  cx;
    logic [SIDE_W-1:0]  px;
    logic signed [9:0]  sy;
    logic signed [9:0]  sx;
    logic signed [9:0]  side_s;
    logic               in_range;
    logic               pad_hit;
    logic               load_ok;
    logic               is_load;

    always_comb
    begin
        eff_side = (int'(cfg.side) > SIDE_CAP) ? SIDE_W'(SIDE_CAP) : cfg.side;
        crop_lim = {cfg.pad, 1'b0};
        cy       = (cfg.crop_y > crop_lim) ? crop_lim : cfg.crop_y;
        cx       = (cfg.crop_x > crop_lim) ? crop_lim : cfg.crop_x;
        in_range = ({1'b0, req.row} < eff_side) && ({1'b0, req.col} < eff_side);
        // mirror inside the cropped patch
        px       = cfg.mirror ? (eff_side - 6'd1 - {1'b0, req.col}) : {1'b0, req.col};
        sy       = $signed({5'd0, req.row}) + $signed({3'd0, cy}) - $signed({4'd0, cfg.pad});
        sx       = $signed({4'd0, px}) + $signed({3'd0, cx}) - $signed({4'd0, cfg.pad});
        side_s   = $signed({4'd0, eff_side});
        pad_hit  = sy[9] || sx[9] || (sy >= side_s) || (sx >= side_s);
        load_ok  = (int'(req.row) < MAX_SIDE) && (int'(req.col) < MAX_SIDE);
        is_load  = (req.action == ACT_LOAD);

        q_cmd.is_load     = is_load;
        q_cmd.word        = req.pixel_in;
        q_cmd.range_error = !is_load && !in_range;
        q_cmd.is_padding  = !is_load && in_range && pad_hit;
        if (is_load)
        begin
            q_cmd.y = {1'b0, req.row};
            q_cmd.x = {1'b0, req.col};
        end
        else
        begin
            q_cmd.y = sy[COORD_W-1:0];
            q_cmd.x = sx[COORD_W-1:0];
        end

        req_ready = q_ready;
        // loads outside the store are taken and dropped
        q_push    = req_valid && q_ready && (!is_load || load_ok);
    end

endmodule

// ===== src/pcfis_queue.sv =====
// short command queue between front and back
// depends on pcfis_pkg (cmd_t, CMD_Q_DEPTH)
module pcfis_queue
    import pcfis_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic push_ready,
    output logic pop_valid,
    input  logic pop_ready,
    output cmd_t pop_cmd
);

    localparam int PTR_W = (CMD_Q_DEPTH > 1) ? $clog2(CMD_Q_DEPTH) : 1;
    localparam int CNT_W = $clog2(CMD_Q_DEPTH + 1);

    cmd_t             slot_reg [CMD_Q_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             pop;

    always_comb
    begin
        push_ready  = (cnt_reg != CNT_W'(CMD_Q_DEPTH));
        pop_valid   = (cnt_reg != '0);
        pop_cmd     = slot_reg[rd_ptr_reg];
        pop         = pop_valid && pop_ready;
        wr_ptr_next = (wr_ptr_reg == PTR_W'(CMD_Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        rd_ptr_next = (rd_ptr_reg == PTR_W'(CMD_Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        cnt_next    = cnt_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_next;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_next;
            end
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== src/pcfis_back.sv =====
// back end: pixel store with registered read and a small result queue
// depends on pcfis_pkg; pops commands from pcfis_queue
module pcfis_back
    import pcfis_pkg::*;
#(
    parameter int MAX_SIDE = 32
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_valid,
    output logic cmd_ready,
    input  cmd_t cmd,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    localparam int DEPTH  = MAX_SIDE * MAX_SIDE;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int OPTR_W = (RSP_Q_DEPTH > 1) ? $clog2(RSP_Q_DEPTH) : 1;
    localparam int OCNT_W = $clog2(RSP_Q_DEPTH + 1);

    logic [PIX_W-1:0]  image_mem [DEPTH];
    logic [PIX_W-1:0]  rd_data_reg;
    logic              rd_pend_reg;
    logic              rd_pad_reg;
    logic              rd_err_reg;

    rsp_t              oq_reg [RSP_Q_DEPTH];
    logic [OPTR_W-1:0] oq_wr_reg;
    logic [OPTR_W-1:0] oq_wr_next;
    logic [OPTR_W-1:0] oq_rd_reg;
    logic [OPTR_W-1:0] oq_rd_next;
    logic [OCNT_W-1:0] oq_cnt_reg;
    logic [OCNT_W-1:0] oq_cnt_next;

    logic [ADDR_W-1:0] addr;
    logic [OCNT_W:0]   committed;
    logic              take;
    logic              wr_en;
    logic              rd_en;
    logic              oq_pop;
    rsp_t              oq_in;

    always_comb
    begin
        addr      = ADDR_W'(cmd.y) * ADDR_W'(MAX_SIDE) + ADDR_W'(cmd.x);
        rsp_valid = (oq_cnt_reg != '0);
        rsp       = oq_reg[oq_rd_reg];
        oq_pop    = rsp_valid && rsp_ready;
        // results queued or in flight after this cycle's transfer
        committed = {1'b0, oq_cnt_reg} + (OCNT_W + 1)'(rd_pend_reg) - (OCNT_W + 1)'(oq_pop);
        cmd_ready = cmd.is_load || (committed < (OCNT_W + 1)'(RSP_Q_DEPTH));
        take      = cmd_valid && cmd_ready;
        wr_en     = take && cmd.is_load;
        rd_en     = take && !cmd.is_load;

        oq_in.pixel_out   = (rd_pad_reg || rd_err_reg) ? '0 : rd_data_reg;
        oq_in.is_padding  = rd_pad_reg;
        oq_in.range_error = rd_err_reg;

        oq_wr_next  = (oq_wr_reg == OPTR_W'(RSP_Q_DEPTH - 1)) ? '0 : oq_wr_reg + 1'b1;
        oq_rd_next  = (oq_rd_reg == OPTR_W'(RSP_Q_DEPTH - 1)) ? '0 : oq_rd_reg + 1'b1;
        oq_cnt_next = oq_cnt_reg + OCNT_W'(rd_pend_reg) - OCNT_W'(oq_pop);
    end

    // single-port store: one write or one read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            image_mem[addr] <= cmd.word;
        end
        else if (rd_en)
        begin
            rd_data_reg <= image_mem[addr];
        end
    end

    always_ff @(posedge clk)
    begin
        rd_pad_reg <= cmd.is_padding;
        rd_err_reg <= cmd.range_error;
        if (rd_pend_reg)
        begin
            oq_reg[oq_wr_reg] <= oq_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_pend_reg <= 1'b0;
            oq_wr_reg   <= '0;
            oq_rd_reg   <= '0;
            oq_cnt_reg  <= '0;
        end
        else
        begin
            rd_pend_reg <= rd_en;
            if (rd_pend_reg)
            begin
                oq_wr_reg <= oq_wr_next;
            end
            if (oq_pop)
            begin
                oq_rd_reg <= oq_rd_next;
            end
            oq_cnt_reg <= oq_cnt_next;
        end
    end

endmodule

// ===== tb/pad_crop_flip_image_store_top_tb.sv =====
// testbench for the pad/crop/flip image store: directed and random loads and fetches
// depends on pcfis_pkg and pad_crop_flip_image_store_top; self-checking against a local view model
`timescale 1ns / 100ps

module pad_crop_flip_image_store_top_tb;
    import pcfis_pkg::*;

    localparam int MAX_SIDE    = 32;
    localparam int CYCLE_LIMIT = 200000;
    localparam logic [2:0] REG_UNUSED = 3'd7;

    typedef struct {
        rsp_t r;
        bit   reads_store;
        int   addr;
    } view_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [CFG_DATA_W-1:0] pwdata = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  req_valid = 1'b0;
    logic                  req_ready;
    req_t                  req = '0;
    logic                  rsp_valid;
    logic                  rsp_ready = 1'b0;
    rsp_t                  rsp;

    // local copy of the image and the register settings
    logic [PIX_W-1:0] image_copy [0:MAX_SIDE*MAX_SIDE-1];
    bit               written [0:MAX_SIDE*MAX_SIDE-1];
    cfg_t             cur_cfg;
    rsp_t             pending_pixels [$];
    int               mismatches = 0;
    int               cycle_count = 0;
    bit               no_gaps = 1'b0;

    pad_crop_flip_image_store_top #(.MAX_SIDE(MAX_SIDE)) uut (
        .clk(clk),
        .rst_n(rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req(req),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp(rsp)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout at cycle %0d, %0d results outstanding",
                     cycle_count, pending_pixels.size());
            $display("Some tests failed");
            $finish;
        end
    end

    always @(negedge clk)
        rsp_ready <= no_gaps || ($urandom_range(99) >= 19);

    // view pixel for a fetch at (row, col) under the current settings
    function automatic view_t view_pixel(logic [IDX_W-1:0] row, logic [IDX_W-1:0] col);
        view_t v;
        int s, p, lim, cy, cx, px, sy, sx, r, c;
        v.r = '0;
        v.reads_store = 1'b0;
        v.addr = 0;
        r = int'(row);
        c = int'(col);
        s = int'(cur_cfg.side);
        if (s > MAX_SIDE)
            s = MAX_SIDE;
        if (r >= s || c >= s)
        begin
            v.r.range_error = 1'b1;
            return v;
        end
        p = int'(cur_cfg.pad);
        lim = 2 * p;
        cy = int'(cur_cfg.crop_y);
        cx = int'(cur_cfg.crop_x);
        if (cy > lim)
            cy = lim;
        if (cx > lim)
            cx = lim;
        px = cur_cfg.mirror ? s - 1 - c : c;
        sy = r + cy - p;
        sx = px + cx - p;
        if (sy < 0 || sy >= s || sx < 0 || sx >= s)
            v.r.is_padding = 1'b1;
        else
        begin
            v.reads_store = 1'b1;
            v.addr = sy * MAX_SIDE + sx;
            v.r.pixel_out = image_copy[v.addr];
        end
        return v;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch at cycle %0d: %s got %h want %h", cycle_count, what, got, want);
        mismatches++;
    endtask

    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (pending_pixels.size() == 0)
                report_mismatch("result with nothing pending", rsp.pixel_out, 32'd0);
            else
            begin
                want = pending_pixels.pop_front();
                if (rsp.pixel_out !== want.pixel_out)
                    report_mismatch("pixel_out", rsp.pixel_out, want.pixel_out);
                if (rsp.is_padding !== want.is_padding)
                    report_mismatch("is_padding", 32'(rsp.is_padding),
                                    32'(want.is_padding));
                if (rsp.range_error !== want.range_error)
                    report_mismatch("range_error", 32'(rsp.range_error),
                                    32'(want.range_error));
            end
        end
    end

    // called at a falling edge; returns at the falling edge after the transfer
    task automatic send_req(input req_t item);
        int a;
        while (!no_gaps && $urandom_range(99) < 19)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        req <= item;
        do @(posedge clk); while (!req_ready);
        if (item.action == ACT_LOAD)
        begin
            a = int'(item.row) * MAX_SIDE + int'(item.col);
            image_copy[a] = item.pixel_in;
            written[a] = 1'b1;
        end
        else
            pending_pixels.insert(pending_pixels.size(), view_pixel(item.row, item.col).r);
        @(negedge clk);
    endtask

    task automatic send_load(input int row, input int col, input logic [PIX_W-1:0] word);
        req_t item;
        item.action = ACT_LOAD;
        item.row = IDX_W'(row);
        item.col = IDX_W'(col);
        item.pixel_in = word;
        send_req(item);
    endtask

    // never reads a store entry that was not loaded: loads it first
    task automatic send_fetch(input int row, input int col);
        req_t item;
        view_t v;
        item.action = ACT_FETCH;
        item.row = IDX_W'(row);
        item.col = IDX_W'(col);
        item.pixel_in = $urandom;
        v = view_pixel(item.row, item.col);
        if (v.reads_store && !written[v.addr])
            send_load(v.addr / MAX_SIDE, v.addr % MAX_SIDE, $urandom);
        send_req(item);
    endtask

    task automatic set_reg(input logic [2:0] idx, input int value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= ($urandom & 32'hFFFF_FF80) | CFG_DATA_W'(value & 32'h7F);
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        case (idx)
            REG_SIDE:   cur_cfg.side = value[SIDE_W-1:0];
            REG_PAD:    cur_cfg.pad = value[SIDE_W-1:0];
            REG_CROP_Y: cur_cfg.crop_y = value[CROP_W-1:0];
            REG_CROP_X: cur_cfg.crop_x = value[CROP_W-1:0];
            REG_MIRROR: cur_cfg.mirror = value[0];
            default:    ;
        endcase
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        req_valid <= 1'b0;
        while (pending_pixels.size() != 0) @(negedge clk);
        // a last load may still be on its way into the store
        repeat (6) @(negedge clk);
    endtask

    task automatic apply_cfg(input int side, input int pad, input int cy, input int cx,
                             input int mir);
        wait_drained();
        set_reg(REG_SIDE, side);
        set_reg(REG_PAD, pad);
        set_reg(REG_CROP_Y, cy);
        set_reg(REG_CROP_X, cx);
        set_reg(REG_MIRROR, mir);
    endtask

    task automatic test_reset_view();
        send_load(0, 0, 32'hFFFF_FFFF);
        send_load(31, 31, 32'h0000_0000);
        send_load(27, 27, 32'hA5A5_5A5A);
        send_fetch(0, 0);       // top-left lands in the padding
        send_fetch(4, 4);       // first stored pixel
        send_fetch(31, 31);
        send_fetch(31, 0);
    endtask

    task automatic test_side_limits();
        apply_cfg(0, 4, 0, 0, 0);       // zero side: every fetch out of range
        send_fetch(0, 0);
        send_fetch(31, 31);
        apply_cfg(63, 0, 0, 0, 0);      // side saturates at the store size
        send_fetch(31, 31);
        send_fetch(0, 0);
        apply_cfg(1, 0, 0, 0, 1);       // one-pixel image, mirrored
        send_fetch(0, 0);
        send_fetch(0, 1);
        send_fetch(1, 0);
    endtask

    task automatic test_crop_clamp_mirror();
        apply_cfg(32, 63, 127, 127, 0); // crops clamp to twice the padding
        send_fetch(0, 0);
        send_fetch(31, 31);
        apply_cfg(32, 2, 100, 3, 1);
        send_fetch(0, 0);
        send_fetch(5, 2);
        send_fetch(31, 31);
        wait_drained();
        set_reg(REG_UNUSED, 127);       // write to a hole in the map changes nothing
        send_fetch(5, 2);
    endtask

    task automatic random_items(input int count);
        repeat (count)
        begin
            if ($urandom_range(99) < 30)
                send_load($urandom_range(31), $urandom_range(31), $urandom);
            else
                send_fetch($urandom_range(31), $urandom_range(31));
        end
    endtask

    task automatic test_random_phases();
        int side, pad, cy, cx;
        for (int ph = 0; ph < 8; ph++)
        begin
            if ($urandom_range(99) < 5)
                side = 0;
            else if ($urandom_range(99) < 8)
                side = $urandom_range(33, 63);
            else
                side = $urandom_range(1, 32);
            pad = ($urandom_range(99) < 10) ? $urandom_range(33, 63) : $urandom_range(0, 16);
            cy = ($urandom_range(99) < 20) ? $urandom_range(127) : $urandom_range(2 * pad);
            cx = ($urandom_range(99) < 20) ? $urandom_range(127) : $urandom_range(2 * pad);
            apply_cfg(side, pad, cy, cx, $urandom_range(1));
            no_gaps = (ph == 3);
            random_items(35);
        end
        no_gaps = 1'b0;
    endtask

    initial
    begin
        cur_cfg.side = SIDE_RESET;
        cur_cfg.pad = PAD_RESET;
        cur_cfg.crop_y = CROP_RESET;
        cur_cfg.crop_x = CROP_RESET;
        cur_cfg.mirror = MIRROR_RESET;
        foreach (written[i])
        begin
            written[i] = 1'b0;
            image_copy[i] = '0;
        end
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_reset_view();
        test_side_limits();
        test_crop_clamp_mirror();
        test_random_phases();

        wait_drained();
        repeat (10) @(negedge clk);
        if (mismatches == 0 && pending_pixels.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
